// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by circle_segment_collision_top.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define CSC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define CSC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/csc_pkg.sv -----
// Shared constants and tables for the circle/segment collision block.
package csc_pkg;

    localparam int COORD_W    = 16;
    localparam int RADIUS_W   = 15;
    localparam int HT_W       = 8;
    localparam int DEPTH_W    = 16;
    localparam int ANGLE_W    = 16;

    localparam int COORD_FRAC_BITS_DEF = 4;

    localparam logic [HT_W-1:0] HALF_THICK_RST = 8'd32;

    localparam int CORDIC_ITERS = 16;

    // atan(2^-i) in 65536ths of a turn
    localparam logic [13:0] ATAN_TURN16 [CORDIC_ITERS] = '{
        14'd8192, 14'd4836, 14'd2555, 14'd1297, 14'd651, 14'd326, 14'd163, 14'd81,
        14'd41, 14'd20, 14'd10, 14'd5, 14'd3, 14'd1, 14'd1, 14'd0
    };

    localparam logic signed [17:0] HALF_TURN = 18'sd32768;

endpackage

// ----- hw/rtl/csc_if.sv -----
// Stream interfaces for queries, results and the configuration write.
interface csc_query_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [csc_pkg::COORD_W-1:0]       center_x;
    logic signed [csc_pkg::COORD_W-1:0]       center_y;
    logic        [csc_pkg::RADIUS_W-1:0]      circle_radius;
    logic signed [csc_pkg::COORD_W-1:0]       seg_start_x;
    logic signed [csc_pkg::COORD_W-1:0]       seg_start_y;
    logic signed [csc_pkg::COORD_W-1:0]       seg_end_x;
    logic signed [csc_pkg::COORD_W-1:0]       seg_end_y;

    modport source (output valid, center_x, center_y, circle_radius, seg_start_x,
                    seg_start_y, seg_end_x, seg_end_y, input ready);
    modport sink   (input valid, center_x, center_y, circle_radius, seg_start_x,
                    seg_start_y, seg_end_x, seg_end_y, output ready);
endinterface

interface csc_result_if;
    logic                              valid;
    logic                              ready;
    logic                              hit_flag;
    logic [csc_pkg::DEPTH_W-1:0]       depth;
    logic [csc_pkg::ANGLE_W-1:0]       push_angle;

    modport source (output valid, hit_flag, depth, push_angle, input ready);
    modport sink   (input valid, hit_flag, depth, push_angle, output ready);
endinterface

interface csc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [csc_pkg::HT_W-1:0]      half_thickness;

    modport source (output valid, half_thickness, input ready);
    modport sink   (input valid, half_thickness, output ready);
endinterface

// ----- hw/rtl/circle_segment_collision_top.sv -----
// Circle against line segment contact test: hit flag, penetration depth, push angle.
// Throughput: one beat per cycle; the whole pipeline advances together, so a stalled
// result at the output holds every stage until it is taken.
// Reset: synchronous active low; clears all stage valid bits and sets half_thickness to 32.
`include "assert_macros.svh"

module circle_segment_collision_top #(
    parameter int COORD_FRAC_BITS = csc_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    csc_query_if.sink    i_in,
    csc_result_if.source o_res,
    csc_cfg_if.sink      i_cfg
);

    // Fixed-point bookkeeping.
    //   UP   : coordinate units -> 1/256 pixel
    //   FINE : exact C-P units (2^-(F+16) px) -> 1/256 px
    //   EW   : width of the rounded C-P components
    //   RW   : width of reach in 1/256 px, also the root width
    localparam int UP   = 8 - COORD_FRAC_BITS;
    localparam int FINE = 8 + COORD_FRAC_BITS;
    localparam int EW   = 28 - COORD_FRAC_BITS;
    localparam int RW   = 24 - COORD_FRAC_BITS;
    localparam int XW   = EW + 1;
    localparam int SQ_SW  = 1 + RW + 2*EW;
    localparam int ANG_SW = 1 + csc_pkg::DEPTH_W;
    localparam int DIV_ST = 16;

    localparam logic [35:0] HALF_FINE  = 36'd1 << (FINE - 1);
    localparam logic [RW:0] HALF_DEPTH = ((RW+1)'(1) << UP) >> 1;

    // ---------------------------------------------------------------------
    // Configuration register: the user must write it only while idle; the block itself
    // does not enforce this. Ready outside reset. ---------------------------------
    logic [csc_pkg::HT_W-1:0] r_half_thick;

    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_thick <= csc_pkg::HALF_THICK_RST;
        end else if (i_cfg.valid) begin
            r_half_thick <= i_cfg.half_thickness;
        end
    end

    // ---------------------------------------------------------------------
    // Global pipeline enable: every stage moves when the output slot frees.
    // No query beat is taken while reset is held.
    // ---------------------------------------------------------------------
    logic en;
    logic ang_v;

    assign en         = !ang_v || o_res.ready;
    assign i_in.ready = en && i_rst_n;

    // ---------------------------------------------------------------------
    // S1: segment direction, center relative to start, reach sum.
    // ---------------------------------------------------------------------
    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [16:0] rx;
        logic signed [16:0] ry;
        logic        [15:0] rsum;
    } t_s1;

    t_s1  n_s1, r_s1;
    logic r_s1_v;

    always_comb begin
        n_s1.dx   = 17'(i_in.seg_end_x) - 17'(i_in.seg_start_x);
        n_s1.dy   = 17'(i_in.seg_end_y) - 17'(i_in.seg_start_y);
        n_s1.rx   = 17'(i_in.center_x) - 17'(i_in.seg_start_x);
        n_s1.ry   = 17'(i_in.center_y) - 17'(i_in.seg_start_y);
        n_s1.rsum = 16'(i_in.circle_radius) + 16'(r_half_thick);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------------------------------------------------------------
    // S2: the four 17x17 products for len2 and dot.
    // ---------------------------------------------------------------------
    typedef struct packed {
        logic signed [33:0] pxx;
        logic signed [33:0] pyy;
        logic signed [33:0] pdx;
        logic signed [33:0] pdy;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [16:0] rx;
        logic signed [16:0] ry;
        logic        [15:0] rsum;
    } t_s2;

    t_s2  n_s2, r_s2;
    logic r_s2_v;

    always_comb begin
        n_s2.pxx  = r_s1.dx * r_s1.dx;
        n_s2.pyy  = r_s1.dy * r_s1.dy;
        n_s2.pdx  = r_s1.rx * r_s1.dx;
        n_s2.pdy  = r_s1.ry * r_s1.dy;
        n_s2.dx   = r_s1.dx;
        n_s2.dy   = r_s1.dy;
        n_s2.rx   = r_s1.rx;
        n_s2.ry   = r_s1.ry;
        n_s2.rsum = r_s1.rsum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2 <= n_s2;
        end
    end

    // ---------------------------------------------------------------------
    // Divider: t = floor(dot * 2^16 / len2), one quotient bit per stage.
    // Entry stage classifies t: zero (before start or point segment),
    // full (past the end) or a true fraction.
    // ---------------------------------------------------------------------
    typedef struct packed {
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [16:0] rx;
        logic signed [16:0] ry;
        logic        [15:0] rsum;
        logic        [33:0] len2;
        logic        [33:0] rem;
        logic        [15:0] q;
        logic               tz;
        logic               tf;
    } t_dv;

    t_dv  r_dv   [DIV_ST+1];
    logic r_dv_v [DIV_ST+1];

    t_dv                n_dv0;
    logic signed [34:0] dot;

    always_comb begin
        dot         = 35'(r_s2.pdx) + 35'(r_s2.pdy);
        n_dv0.dx    = r_s2.dx;
        n_dv0.dy    = r_s2.dy;
        n_dv0.rx    = r_s2.rx;
        n_dv0.ry    = r_s2.ry;
        n_dv0.rsum  = r_s2.rsum;
        n_dv0.len2  = $unsigned(r_s2.pxx) + $unsigned(r_s2.pyy);
        n_dv0.q     = '0;
        n_dv0.tz    = (n_dv0.len2 == '0) || (dot <= 35'sd0);
        n_dv0.tf    = !n_dv0.tz && (36'(dot) >= $signed({2'b00, n_dv0.len2}));
        n_dv0.rem   = (n_dv0.tz || n_dv0.tf) ? '0 : dot[33:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0] <= n_dv0;
        end
    end

    for (genvar k = 1; k <= DIV_ST; k++) begin : g_div
        t_dv         n_dv;
        logic [34:0] sh;
        logic [34:0] sub;
        logic        ge;

        always_comb begin
            sh   = {r_dv[k-1].rem, 1'b0};
            sub  = sh - {1'b0, r_dv[k-1].len2};
            ge   = sh >= {1'b0, r_dv[k-1].len2};
            n_dv = r_dv[k-1];
            n_dv.rem = ge ? sub[33:0] : sh[33:0];
            n_dv.q   = {r_dv[k-1].q[14:0], ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else if (en) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[k] <= n_dv;
            end
        end
    end

    // ---------------------------------------------------------------------
    // S4: t * d for both axes.
    // ---------------------------------------------------------------------
    typedef struct packed {
        logic signed [34:0] tdx;
        logic signed [34:0] tdy;
        logic signed [16:0] rx;
        logic signed [16:0] ry;
        logic        [15:0] rsum;
    } t_s4;

    t_s4         n_s4, r_s4;
    logic        r_s4_v;
    logic [16:0] t_par;

    always_comb begin
        priority if (r_dv[DIV_ST].tz) begin
            t_par = '0;
        end else if (r_dv[DIV_ST].tf) begin
            t_par = 17'h10000;
        end else begin
            t_par = {1'b0, r_dv[DIV_ST].q};
        end
        n_s4.tdx  = $signed({1'b0, t_par}) * r_dv[DIV_ST].dx;
        n_s4.tdy  = $signed({1'b0, t_par}) * r_dv[DIV_ST].dy;
        n_s4.rx   = r_dv[DIV_ST].rx;
        n_s4.ry   = r_dv[DIV_ST].ry;
        n_s4.rsum = r_dv[DIV_ST].rsum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= r_dv_v[DIV_ST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4 <= n_s4;
        end
    end

    // ---------------------------------------------------------------------
    // S5: C-P exactly, then rounded to 1/256 px, ties away from zero.
    // ---------------------------------------------------------------------
    function automatic logic signed [EW-1:0] round_fine(input logic signed [35:0] d);
        logic [35:0] mag;
        logic [35:0] r;
        mag = d[35] ? 36'(-d) : d;
        r   = (mag + HALF_FINE) >> FINE;
        return d[35] ? -$signed(r[EW-1:0]) : $signed(r[EW-1:0]);
    endfunction

    typedef struct packed {
        logic signed [EW-1:0] ex;
        logic signed [EW-1:0] ey;
        logic        [15:0]   rsum;
    } t_s5;

    t_s5                n_s5, r_s5;
    logic               r_s5_v;
    logic signed [35:0] fx;
    logic signed [35:0] fy;

    always_comb begin
        fx = 36'($signed({r_s4.rx, 16'h0000})) - 36'(r_s4.tdx);
        fy = 36'($signed({r_s4.ry, 16'h0000})) - 36'(r_s4.tdy);
        n_s5.ex   = round_fine(fx);
        n_s5.ey   = round_fine(fy);
        n_s5.rsum = r_s4.rsum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
        end else if (en) begin
            r_s5_v <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5 <= n_s5;
        end
    end

    // ---------------------------------------------------------------------
    // S6: squares of the distance components and of the reach.
    // ---------------------------------------------------------------------
    typedef struct packed {
        logic        [2*EW-1:0] ex2;
        logic        [2*EW-1:0] ey2;
        logic        [RW-1:0]   reach;
        logic        [2*RW-1:0] r2;
        logic signed [EW-1:0]   ex;
        logic signed [EW-1:0]   ey;
    } t_s6;

    t_s6  n_s6, r_s6;
    logic r_s6_v;

    always_comb begin
        n_s6.ex2   = r_s5.ex * r_s5.ex;
        n_s6.ey2   = r_s5.ey * r_s5.ey;
        n_s6.reach = RW'(r_s5.rsum) << UP;
        n_s6.r2    = n_s6.reach * n_s6.reach;
        n_s6.ex    = r_s5.ex;
        n_s6.ey    = r_s5.ey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_v <= 1'b0;
        end else if (en) begin
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6 <= n_s6;
        end
    end

    // ---------------------------------------------------------------------
    // S7: hit test on squares; the root is only needed on a hit, where
    // d2 <= reach^2 keeps the radicand inside 2*RW bits.
    // ---------------------------------------------------------------------
    typedef struct packed {
        logic                   hit;
        logic        [2*RW-1:0] rad;
        logic        [RW-1:0]   reach;
        logic signed [EW-1:0]   ex;
        logic signed [EW-1:0]   ey;
    } t_s7;

    t_s7         n_s7, r_s7;
    logic        r_s7_v;
    logic [2*EW:0] d2;

    always_comb begin
        d2         = {1'b0, r_s6.ex2} + {1'b0, r_s6.ey2};
        n_s7.hit   = d2 <= (2*EW+1)'(r_s6.r2);
        n_s7.rad   = n_s7.hit ? d2[2*RW-1:0] : '0;
        n_s7.reach = r_s6.reach;
        n_s7.ex    = r_s6.ex;
        n_s7.ey    = r_s6.ey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_v <= 1'b0;
        end else if (en) begin
            r_s7_v <= r_s6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7 <= n_s7;
        end
    end

    // ---------------------------------------------------------------------
    // Square root pipeline, RW stages.
    // ---------------------------------------------------------------------
    logic             sq_v;
    logic [RW-1:0]    sq_root;
    logic [SQ_SW-1:0] sq_side;

    csc_isqrt #(
        .RW (RW),
        .SW (SQ_SW)
    ) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s7_v),
        .i_rad   (r_s7.rad),
        .i_side  ({r_s7.hit, r_s7.reach, r_s7.ex, r_s7.ey}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // ---------------------------------------------------------------------
    // S8: depth back in coordinate units with round-half-up; angle input
    // is (ex, -ey) so the angle counts counterclockwise with y down.
    // ---------------------------------------------------------------------
    typedef struct packed {
        logic                           hit;
        logic [csc_pkg::DEPTH_W-1:0]    depth;
        logic signed [XW-1:0]           ax;
        logic signed [XW-1:0]           ay;
    } t_s8;

    t_s8                  n_s8, r_s8;
    logic                 r_s8_v;
    logic                 s8_hit;
    logic [RW-1:0]        s8_reach;
    logic signed [EW-1:0] s8_ex;
    logic signed [EW-1:0] s8_ey;
    logic [RW:0]          dep_full;
    logic [RW:0]          dep_sh;

    always_comb begin
        s8_hit   = sq_side[SQ_SW-1];
        s8_reach = sq_side[SQ_SW-2 -: RW];
        s8_ex    = $signed(sq_side[2*EW-1:EW]);
        s8_ey    = $signed(sq_side[EW-1:0]);
        dep_full = (RW+1)'(s8_reach) - (RW+1)'(sq_root) + HALF_DEPTH;
        dep_sh   = dep_full >> UP;
        n_s8.hit = s8_hit;
        priority if (!s8_hit) begin
            n_s8.depth = '0;
        end else if (|dep_sh[RW:csc_pkg::DEPTH_W]) begin
            n_s8.depth = '1;
        end else begin
            n_s8.depth = dep_sh[csc_pkg::DEPTH_W-1:0];
        end
        n_s8.ax = XW'(s8_ex);
        n_s8.ay = -XW'(s8_ey);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_v <= 1'b0;
        end else if (en) begin
            r_s8_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s8 <= n_s8;
        end
    end

    // ---------------------------------------------------------------------
    // Angle pipeline: 5 normalize stages, a half-plane fold, 16 CORDIC steps.
    // Its last register is the output register.
    // ---------------------------------------------------------------------
    logic [csc_pkg::ANGLE_W-1:0] ang_angle;
    logic [ANG_SW-1:0]           ang_side;

    csc_angle #(
        .XW (XW),
        .SW (ANG_SW)
    ) u_angle (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s8_v),
        .i_x     (r_s8.ax),
        .i_y     (r_s8.ay),
        .i_side  ({r_s8.hit, r_s8.depth}),
        .o_valid (ang_v),
        .o_angle (ang_angle),
        .o_side  (ang_side)
    );

    assign o_res.valid      = ang_v;
    assign o_res.hit_flag   = ang_side[ANG_SW-1];
    assign o_res.depth      = ang_side[csc_pkg::DEPTH_W-1:0];
    assign o_res.push_angle = ang_angle;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `CSC_ASSERT_NXT(a_entry_beat, i_clk, i_rst_n, i_in.valid && i_in.ready, r_s1_v, "accepted beat did not enter the pipeline")
    `CSC_ASSERT_IMP(a_t_class, i_clk, i_rst_n, r_dv_v[0], !(r_dv[0].tz && r_dv[0].tf), "t classified both zero and full")
    `CSC_ASSERT_IMP(a_rad_gate, i_clk, i_rst_n, r_s7_v && !r_s7.hit, r_s7.rad == '0, "radicand not cleared on a miss")
    `CSC_ASSERT_IMP(a_miss_depth, i_clk, i_rst_n, o_res.valid && !o_res.hit_flag, o_res.depth == '0, "nonzero depth without a hit")

endmodule

// ----- hw/rtl/csc_isqrt.sv -----
// Pipelined integer square root, one root bit per stage, with side data.
module csc_isqrt #(
    parameter int RW = 20,
    parameter int SW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_rad,
    input  logic [SW-1:0]   i_side,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [SW-1:0]   o_side
);

    typedef struct packed {
        logic [RW+1:0]   rem;
        logic [RW-1:0]   root;
        logic [2*RW-1:0] rad;
        logic [SW-1:0]   side;
    } t_sq;

    t_sq  r_st [RW];
    logic r_v  [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        t_sq          prev;
        t_sq          n_st;
        logic         prev_v;
        logic [RW+3:0] cur;
        logic [RW+3:0] trial;
        logic [RW+3:0] diff;

        if (k == 0) begin : g_first
            assign prev   = '{rem: '0, root: '0, rad: i_rad, side: i_side};
            assign prev_v = i_valid;
        end else begin : g_next
            assign prev   = r_st[k-1];
            assign prev_v = r_v[k-1];
        end

        always_comb begin
            cur   = {prev.rem, prev.rad[2*RW-1 -: 2]};
            trial = {2'b00, prev.root, 2'b01};
            diff  = cur - trial;
            n_st      = prev;
            n_st.rad  = prev.rad << 2;
            if (cur >= trial) begin
                n_st.rem  = diff[RW+1:0];
                n_st.root = {prev.root[RW-2:0], 1'b1};
            end else begin
                n_st.rem  = cur[RW+1:0];
                n_st.root = {prev.root[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= prev_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_st[RW-1].root;
    assign o_side  = r_st[RW-1].side;

endmodule

// ----- hw/rtl/csc_angle.sv -----
// Pipelined vector angle: normalize, fold to right half plane, CORDIC vectoring.
module csc_angle #(
    parameter int XW = 25,
    parameter int SW = 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [XW-1:0]         i_x,
    input  logic signed [XW-1:0]         i_y,
    input  logic [SW-1:0]                i_side,
    output logic                         o_valid,
    output logic [csc_pkg::ANGLE_W-1:0]  o_angle,
    output logic [SW-1:0]                o_side
);

    localparam int NORM_ST = 5;
    localparam int NST     = NORM_ST + 1 + csc_pkg::CORDIC_ITERS;

    typedef struct packed {
        logic signed [34:0] x;
        logic signed [34:0] y;
        logic signed [17:0] z;
        logic               zf;
        logic [SW-1:0]      side;
    } t_ang;

    t_ang r_st [NST];
    logic r_v  [NST];

    for (genvar k = 0; k < NST; k++) begin : g_stage
        t_ang prev;
        t_ang n_st;
        logic prev_v;

        if (k == 0) begin : g_first
            assign prev.x    = {{(35-XW){i_x[XW-1]}}, i_x};
            assign prev.y    = {{(35-XW){i_y[XW-1]}}, i_y};
            assign prev.z    = '0;
            assign prev.zf   = (i_x == '0) && (i_y == '0);
            assign prev.side = i_side;
            assign prev_v    = i_valid;
        end else begin : g_next
            assign prev   = r_st[k-1];
            assign prev_v = r_v[k-1];
        end

        if (k < NORM_ST) begin : g_norm
            // shift up by M while both magnitudes are below 2^(31-M), keeping them below 2^31
            localparam int M = 16 >> k;
            localparam logic [34:0] THR = 35'd1 << (31 - M);
            logic [34:0] ax;
            logic [34:0] ay;
            always_comb begin
                ax   = prev.x[34] ? 35'(-prev.x) : prev.x;
                ay   = prev.y[34] ? 35'(-prev.y) : prev.y;
                n_st = prev;
                if ((ax < THR) && (ay < THR)) begin
                    n_st.x = prev.x <<< M;
                    n_st.y = prev.y <<< M;
                end
            end
        end else if (k == NORM_ST) begin : g_fold
            always_comb begin
                n_st = prev;
                if (prev.x[34]) begin
                    n_st.x = -prev.x;
                    n_st.y = -prev.y;
                    n_st.z = csc_pkg::HALF_TURN;
                end
            end
        end else begin : g_cordic
            localparam int I = k - NORM_ST - 1;
            logic signed [34:0] xs;
            logic signed [34:0] ys;
            logic signed [17:0] at;
            always_comb begin
                xs   = prev.x >>> I;
                ys   = prev.y >>> I;
                at   = $signed({4'b0000, csc_pkg::ATAN_TURN16[I]});
                n_st = prev;
                if (!prev.y[34] && (prev.y != '0)) begin
                    n_st.x = prev.x + ys;
                    n_st.y = prev.y - xs;
                    n_st.z = prev.z + at;
                end else begin
                    n_st.x = prev.x - ys;
                    n_st.y = prev.y + xs;
                    n_st.z = prev.z - at;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= prev_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= n_st;
            end
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_angle = r_st[NST-1].zf ? '0 : r_st[NST-1].z[csc_pkg::ANGLE_W-1:0];
    assign o_side  = r_st[NST-1].side;

endmodule
